// File: rtl/core/ppmfd_pkg.sv
// Shared constants and types for the PPM frame decoder.
package ppmfd_pkg;

    // Channels per frame
    localparam int NUM_CHANNELS = 10;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int WIDTH_W = 16;
    localparam int IDX_W   = 4;

    // Channel RAM address and channel counter widths
    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register map, indexed by paddr[3:2]
    typedef enum logic [1:0] {
        REG_PULSE_MIN  = 2'd0,
        REG_PULSE_MAX  = 2'd1,
        REG_LOCKED_GAP = 2'd2,
        REG_SYNC_GAP   = 2'd3
    } t_reg_idx;

    // Register reset values
    localparam logic [WIDTH_W-1:0] RST_PULSE_MIN  = 16'd800;
    localparam logic [WIDTH_W-1:0] RST_PULSE_MAX  = 16'd2200;
    localparam logic [WIDTH_W-1:0] RST_LOCKED_GAP = 16'd2000;
    localparam logic [WIDTH_W-1:0] RST_SYNC_GAP   = 16'd2500;

endpackage

// File: rtl/core/ppm_frame_decoder.sv
// PPM frame decoder: edge timestamps in, channel widths of each frame out.
//
// Every transaction on the input carries the microsecond timestamp of one
// rising PPM edge; the block takes one per cycle. The 16-bit delta from the
// previous edge drives the lock and capture logic, and each channel width
// in the pulse window is written to a 10-entry channel RAM. The edge that
// completes the tenth channel starts a run of ten output transactions,
// channel 0 to 9, with o_last_channel on the last; the run drains at one
// per cycle, stalled by i_out_ready, through the RAM's single registered
// read port, which is also the output register. While a run drains, edges
// keep being accepted as long as the decoder is unlocked; once locked
// again the input holds off until the run has finished, so a new frame
// never overwrites a channel not yet sent. The RAM needs no clearing pass:
// every run reads only entries written since the last lock. Registers are
// written over APB at byte addresses 0, 4, 8 and 12; pready is tied high.
module ppm_frame_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Edge input
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ppmfd_pkg::TIME_W-1:0] i_edge_time_us,
    // Channel output
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ppmfd_pkg::IDX_W-1:0]  o_channel_index,
    output logic [ppmfd_pkg::WIDTH_W-1:0] o_channel_width_us,
    output logic                         o_last_channel,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppmfd_pkg::APB_AW-1:0] paddr,
    input  logic [ppmfd_pkg::APB_DW-1:0] pwdata,
    output logic [ppmfd_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import ppmfd_pkg::*;

    // Configuration registers
    logic [WIDTH_W-1:0] r_pulse_min;
    logic [WIDTH_W-1:0] r_pulse_max;
    logic [WIDTH_W-1:0] r_locked_gap;
    logic [WIDTH_W-1:0] r_sync_gap;

    // Decoder state
    logic [WIDTH_W-1:0] r_prev_time;
    logic               r_locked;
    logic [CNT_W-1:0]   r_taken;
    logic               r_emit_active;
    logic [ADDR_W-1:0]  r_emit_idx;

    // Output register
    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_idx;
    logic               r_out_last;
    logic [WIDTH_W-1:0] r_rd_data;

    // Channel RAM
    logic [WIDTH_W-1:0] r_chan_mem [NUM_CHANNELS];

    // Next values
    logic               n_locked;
    logic [CNT_W-1:0]   n_taken;
    logic               n_emit_active;
    logic [ADDR_W-1:0]  n_emit_idx;
    logic               n_out_valid;

    logic               in_accept;
    logic               cfg_write;
    t_reg_idx           cfg_idx;
    logic [WIDTH_W-1:0] delta;
    logic               in_window;
    logic [CNT_W-1:0]   taken_inc;
    logic               chan_write;
    logic               frame_done;
    logic               rd_issue;
    logic               emit_last;

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min  <= RST_PULSE_MIN;
            r_pulse_max  <= RST_PULSE_MAX;
            r_locked_gap <= RST_LOCKED_GAP;
            r_sync_gap   <= RST_SYNC_GAP;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_PULSE_MIN:  r_pulse_min  <= pwdata[WIDTH_W-1:0];
                REG_PULSE_MAX:  r_pulse_max  <= pwdata[WIDTH_W-1:0];
                REG_LOCKED_GAP: r_locked_gap <= pwdata[WIDTH_W-1:0];
                REG_SYNC_GAP:   r_sync_gap   <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PULSE_MIN:  prdata = APB_DW'(r_pulse_min);
            REG_PULSE_MAX:  prdata = APB_DW'(r_pulse_max);
            REG_LOCKED_GAP: prdata = APB_DW'(r_locked_gap);
            REG_SYNC_GAP:   prdata = APB_DW'(r_sync_gap);
            default:        prdata = '0;
        endcase
    end

    // Input hold-off: a locked decoder may write a RAM entry the run still needs
    assign o_in_ready = ~r_emit_active | ~r_locked;
    assign in_accept  = i_in_valid & o_in_ready;

    // Edge delta, modulo 2^16
    assign delta      = i_edge_time_us[WIDTH_W-1:0] - r_prev_time;
    assign in_window  = (delta >= r_pulse_min) && (delta <= r_pulse_max);
    assign taken_inc  = r_taken + CNT_W'(1);
    assign chan_write = in_accept & r_locked & in_window;
    assign frame_done = chan_write && (taken_inc >= CNT_W'(NUM_CHANNELS));

    // Run drain: issue a RAM read whenever the output register frees up
    assign rd_issue  = r_emit_active & (~r_out_valid | i_out_ready);
    assign emit_last = (r_emit_idx == ADDR_W'(NUM_CHANNELS - 1));

    // Lock and capture next state
    always_comb begin
        n_locked = r_locked;
        n_taken  = r_taken;
        if (in_accept) begin
            if (r_locked) begin
                if (in_window) begin
                    n_taken  = taken_inc;
                    n_locked = ~frame_done;
                end else if (delta >= r_locked_gap) begin
                    n_taken = '0;
                end else begin
                    n_locked = 1'b0;
                end
            end else if (delta >= r_sync_gap) begin
                n_locked = 1'b1;
                n_taken  = '0;
            end
        end
    end

    // Run sequencing next state
    always_comb begin
        n_emit_active = r_emit_active;
        n_emit_idx    = r_emit_idx;
        n_out_valid   = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (rd_issue) begin
            n_out_valid = 1'b1;
            n_emit_idx  = r_emit_idx + ADDR_W'(1);
            if (emit_last) begin
                n_emit_active = 1'b0;
            end
        end
        if (frame_done) begin
            n_emit_active = 1'b1;
            n_emit_idx    = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time   <= '0;
            r_locked      <= 1'b0;
            r_taken       <= '0;
            r_emit_active <= 1'b0;
            r_emit_idx    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_prev_time <= i_edge_time_us[WIDTH_W-1:0];
            end
            r_locked      <= n_locked;
            r_taken       <= n_taken;
            r_emit_active <= n_emit_active;
            r_emit_idx    <= n_emit_idx;
            r_out_valid   <= n_out_valid;
        end
    end

    // Channel RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (chan_write) begin
            r_chan_mem[r_taken[ADDR_W-1:0]] <= delta;
        end
        if (rd_issue) begin
            r_rd_data <= r_chan_mem[r_emit_idx];
        end
    end

    // Output payload tags
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_out_idx  <= r_emit_idx;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_channel_index    = IDX_W'(r_out_idx);
    assign o_channel_width_us = r_rd_data;
    assign o_last_channel     = r_out_last;

endmodule
